@@ rtl/core/ehpp_pkg.sv @@
`timescale 1ns / 1ps

package ehpp_pkg;

    localparam int BAND_COUNT = 8;
    localparam int BAND_IDX_W = $clog2(BAND_COUNT);
    localparam int POS_W      = 9;
    localparam int OFF_W      = 5;

    localparam logic [7:0] NO_CONTACT = 8'd200;
    localparam logic [7:0] RAW_LEN    = 8'd2;
    localparam logic [7:0] BAND_LEN   = 8'd24;

    localparam logic [POS_W-1:0] NEED_SHORT = POS_W'(1);
    localparam logic [POS_W-1:0] NEED_RAW   = POS_W'(3);
    localparam logic [POS_W-1:0] NEED_BAND  = POS_W'(25);

    localparam logic [OFF_W-1:0] OFF_LEN = OFF_W'(1);
    localparam logic [OFF_W-1:0] OFF_HI  = OFF_W'(2);

    localparam int FE_ATT  = 0;
    localparam int FE_MED  = 1;
    localparam int FE_RAW  = 2;
    localparam int FE_BAND = 3;

    typedef enum logic [2:0] {
        REG_SYNC_FIRST,
        REG_SYNC_SECOND,
        REG_CODE_QUALITY,
        REG_CODE_ATTENTION,
        REG_CODE_MEDITATION,
        REG_CODE_RAW_WAVE,
        REG_CODE_BAND_POWER,
        REG_FEATURE_ENABLES
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] code_quality;
        logic [7:0] code_attention;
        logic [7:0] code_meditation;
        logic [7:0] code_raw_wave;
        logic [7:0] code_band_power;
        logic [3:0] feature_enables;
    } codes_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic       go;
        logic       bad;
        logic [7:0] len;
    } walk_cmd_t;

    typedef struct packed {
        logic busy;
    } walk_stat_t;

endpackage

@@ rtl/core/ehpp_if.sv @@
`timescale 1ns / 1ps

interface ehpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ehpp_res_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic [7:0]         quality;
    logic               quality_good;
    logic [7:0]         attention;
    logic [7:0]         meditation;
    logic signed [15:0] raw_sample;
    logic [2:0]         band_index;
    logic [23:0]        band_value;
    logic               last;

    modport source (output valid, output status, output quality, output quality_good,
                    output attention, output meditation, output raw_sample,
                    output band_index, output band_value, output last, input ready);
    modport sink (input valid, input status, input quality, input quality_good,
                  input attention, input meditation, input raw_sample,
                  input band_index, input band_value, input last, output ready);
endinterface

interface ehpp_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/ehpp_walker.sv @@
`timescale 1ns / 1ps

module ehpp_walker import ehpp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 169
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  codes_t     codes,
    input  mem_wr_t    wr,
    input  walk_cmd_t  cmd,
    output walk_stat_t stat,
    ehpp_res_if.source res
);

    localparam int AW = $clog2(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        W_IDLE,
        W_CODE_REQ,
        W_CODE,
        W_BODY,
        W_COMMIT,
        W_EMIT
    } state_t;

    typedef enum logic [2:0] {
        ROW_SKIP,
        ROW_QUALITY,
        ROW_ATTENTION,
        ROW_MEDITATION,
        ROW_RAW,
        ROW_BAND
    } row_kind_t;

    logic [7:0] mem [MAX_PAYLOAD];
    logic [7:0] rd_data_reg;

    state_t              state_reg;
    logic                bad_reg;
    logic [7:0]          len_reg;
    logic [POS_W-1:0]    row_pos_reg;
    logic [POS_W-1:0]    ptr_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [OFF_W-1:0]    last_off_reg;
    row_kind_t           kind_reg;
    logic                ok_reg;
    logic                seen_reg;
    logic [7:0]          qual_reg;
    logic [7:0]          att_reg;
    logic [7:0]          med_reg;
    logic [15:0]         acc_reg;
    logic [BAND_IDX_W-1:0] band_k_reg;
    logic [1:0]          tri_reg;
    logic [BAND_IDX_W-1:0] idx_reg;
    logic [7:0]          quality_reg;
    logic [7:0]          attention_reg;
    logic [7:0]          meditation_reg;
    logic [15:0]         raw_reg;
    logic                good_ind_reg;
    logic [23:0]         band_regs [BAND_COUNT];

    row_kind_t        code_kind;
    logic [POS_W-1:0] need;
    logic [POS_W-1:0] len_pos;
    logic             row_fits;
    logic [POS_W-1:0] row_next;
    logic             last_item;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        rd_data_reg <= mem[ptr_reg[AW-1:0]];
    end

    always_comb
    begin
        code_kind = ROW_SKIP;
        need      = '0;
        priority if (rd_data_reg == codes.code_quality)
        begin
            code_kind = ROW_QUALITY;
            need      = NEED_SHORT;
        end
        else if (rd_data_reg == codes.code_attention)
        begin
            code_kind = ROW_ATTENTION;
            need      = NEED_SHORT;
        end
        else if (rd_data_reg == codes.code_meditation)
        begin
            code_kind = ROW_MEDITATION;
            need      = NEED_SHORT;
        end
        else if (rd_data_reg == codes.code_raw_wave)
        begin
            code_kind = ROW_RAW;
            need      = NEED_RAW;
        end
        else if (rd_data_reg == codes.code_band_power)
        begin
            code_kind = ROW_BAND;
            need      = NEED_BAND;
        end
        else
        begin
            code_kind = ROW_SKIP;
        end
    end

    assign len_pos   = POS_W'(len_reg);
    assign row_fits  = (row_pos_reg + need) < len_pos;
    assign row_next  = row_pos_reg + POS_W'(last_off_reg) + POS_W'(1);
    assign last_item = bad_reg || (idx_reg == BAND_IDX_W'(BAND_COUNT - 1));

    assign stat.busy = (state_reg != W_IDLE);

    assign res.valid        = (state_reg == W_EMIT);
    assign res.status       = bad_reg;
    assign res.quality      = quality_reg;
    assign res.quality_good = good_ind_reg;
    assign res.attention    = attention_reg;
    assign res.meditation   = meditation_reg;
    assign res.raw_sample   = raw_reg;
    assign res.band_index   = idx_reg;
    assign res.band_value   = bad_reg ? 24'd0 : band_regs[idx_reg];
    assign res.last         = last_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= W_IDLE;
            bad_reg        <= 1'b0;
            len_reg        <= '0;
            row_pos_reg    <= '0;
            ptr_reg        <= '0;
            off_reg        <= '0;
            last_off_reg   <= '0;
            kind_reg       <= ROW_SKIP;
            ok_reg         <= 1'b0;
            seen_reg       <= 1'b0;
            qual_reg       <= NO_CONTACT;
            att_reg        <= '0;
            med_reg        <= '0;
            acc_reg        <= '0;
            band_k_reg     <= '0;
            tri_reg        <= '0;
            idx_reg        <= '0;
            quality_reg    <= '0;
            attention_reg  <= '0;
            meditation_reg <= '0;
            raw_reg        <= '0;
            good_ind_reg   <= 1'b0;
            for (int k = 0; k < BAND_COUNT; k++)
            begin
                band_regs[k] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                W_IDLE:
                begin
                    if (cmd.go)
                    begin
                        bad_reg     <= cmd.bad;
                        len_reg     <= cmd.len;
                        row_pos_reg <= '0;
                        ptr_reg     <= '0;
                        seen_reg    <= 1'b0;
                        qual_reg    <= NO_CONTACT;
                        att_reg     <= '0;
                        med_reg     <= '0;
                        idx_reg     <= '0;
                        state_reg   <= cmd.bad ? W_EMIT : W_CODE_REQ;
                    end
                end
                W_CODE_REQ:
                begin
                    if (row_pos_reg >= len_pos)
                    begin
                        state_reg <= W_COMMIT;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + POS_W'(1);
                        state_reg <= W_CODE;
                    end
                end
                W_CODE:
                begin
                    if (code_kind == ROW_SKIP)
                    begin
                        row_pos_reg <= row_pos_reg + POS_W'(1);
                        ptr_reg     <= row_pos_reg + POS_W'(1);
                        state_reg   <= W_CODE_REQ;
                    end
                    else if (!row_fits)
                    begin
                        state_reg <= W_COMMIT;
                    end
                    else
                    begin
                        kind_reg     <= code_kind;
                        last_off_reg <= need[OFF_W-1:0];
                        off_reg      <= OFF_LEN;
                        ptr_reg      <= ptr_reg + POS_W'(1);
                        band_k_reg   <= '0;
                        tri_reg      <= '0;
                        state_reg    <= W_BODY;
                    end
                end
                W_BODY:
                begin
                    ptr_reg <= ptr_reg + POS_W'(1);
                    off_reg <= off_reg + OFF_W'(1);
                    unique case (kind_reg)
                        ROW_QUALITY:
                        begin
                            quality_reg <= rd_data_reg;
                            qual_reg    <= rd_data_reg;
                            seen_reg    <= 1'b1;
                        end
                        ROW_ATTENTION:
                        begin
                            if (codes.feature_enables[FE_ATT])
                            begin
                                att_reg <= rd_data_reg;
                            end
                        end
                        ROW_MEDITATION:
                        begin
                            if (codes.feature_enables[FE_MED])
                            begin
                                med_reg <= rd_data_reg;
                            end
                        end
                        ROW_RAW:
                        begin
                            if (off_reg == OFF_LEN)
                            begin
                                ok_reg <= codes.feature_enables[FE_RAW]
                                          && (rd_data_reg == RAW_LEN);
                            end
                            else if (off_reg == OFF_HI)
                            begin
                                acc_reg[7:0] <= rd_data_reg;
                            end
                            else if (ok_reg)
                            begin
                                raw_reg <= {acc_reg[7:0], rd_data_reg};
                            end
                        end
                        ROW_BAND:
                        begin
                            if (off_reg == OFF_LEN)
                            begin
                                ok_reg <= codes.feature_enables[FE_BAND]
                                          && (rd_data_reg == BAND_LEN);
                            end
                            else if (tri_reg == 2'd2)
                            begin
                                tri_reg    <= '0;
                                band_k_reg <= band_k_reg + BAND_IDX_W'(1);
                                if (ok_reg)
                                begin
                                    band_regs[band_k_reg] <= {acc_reg, rd_data_reg};
                                end
                            end
                            else
                            begin
                                tri_reg <= tri_reg + 2'd1;
                                acc_reg <= {acc_reg[7:0], rd_data_reg};
                            end
                        end
                        ROW_SKIP:
                        begin
                        end
                    endcase
                    if (off_reg == last_off_reg)
                    begin
                        row_pos_reg <= row_next;
                        ptr_reg     <= row_next;
                        state_reg   <= W_CODE_REQ;
                    end
                end
                W_COMMIT:
                begin
                    if (seen_reg)
                    begin
                        good_ind_reg <= (qual_reg == 8'd0);
                        if (codes.feature_enables[FE_ATT])
                        begin
                            attention_reg <= att_reg;
                        end
                        if (codes.feature_enables[FE_MED])
                        begin
                            meditation_reg <= med_reg;
                        end
                    end
                    state_reg <= W_EMIT;
                end
                W_EMIT:
                begin
                    if (res.ready)
                    begin
                        if (last_item)
                        begin
                            state_reg <= W_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + BAND_IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/eeg_headset_packet_parser.sv @@
`timescale 1ns / 1ps

// Serial EEG headset packet parser. Bytes before the checksum byte are taken
// one per cycle: sync hunt, length (above MAX_PAYLOAD drops the frame), then
// payload bytes written into a payload store and summed. The checksum byte
// starts a row walk that reads the store through its single registered read
// port: each row code is fetched in W_CODE_REQ and decoded in W_CODE, each row
// body byte is read in W_BODY. A good packet then delivers eight band results,
// a checksum mismatch one status result, one transfer per cycle while res.ready
// is high. rx.ready stays low from the checksum byte until the last result
// transfer. Configuration writes are always taken and must be issued while no
// packet is in flight. The payload store needs no clearing after reset.
module eeg_headset_packet_parser import ehpp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 169
)
(
    input  logic       clk,
    input  logic       rst_n,
    ehpp_byte_if.sink  rx,
    ehpp_res_if.source res,
    ehpp_cfg_if.sink   cfg
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_DATA,
        PH_CSUM
    } phase_t;

    phase_t     phase_reg;
    logic [7:0] len_reg;
    logic [7:0] byte_count_reg;
    logic [7:0] sum_reg;
    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    codes_t     codes_reg;

    logic       accept;
    logic [7:0] count_next;
    walk_cmd_t  cmd;
    mem_wr_t    wr;
    walk_stat_t stat;

    assign rx.ready   = !stat.busy;
    assign cfg.ready  = 1'b1;
    assign accept     = rx.valid && rx.ready;
    assign count_next = byte_count_reg + 8'd1;

    assign cmd.go  = accept && (phase_reg == PH_CSUM);
    assign cmd.bad = (rx.rx_byte != ~sum_reg);
    assign cmd.len = len_reg;

    assign wr.en   = accept && (phase_reg == PH_DATA);
    assign wr.addr = byte_count_reg;
    assign wr.data = rx.rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg            <= 8'd170;
            sync_second_reg           <= 8'd170;
            codes_reg.code_quality    <= 8'd2;
            codes_reg.code_attention  <= 8'd4;
            codes_reg.code_meditation <= 8'd5;
            codes_reg.code_raw_wave   <= 8'd128;
            codes_reg.code_band_power <= 8'd131;
            codes_reg.feature_enables <= 4'hF;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_SYNC_FIRST:      sync_first_reg            <= cfg.data;
                REG_SYNC_SECOND:     sync_second_reg           <= cfg.data;
                REG_CODE_QUALITY:    codes_reg.code_quality    <= cfg.data;
                REG_CODE_ATTENTION:  codes_reg.code_attention  <= cfg.data;
                REG_CODE_MEDITATION: codes_reg.code_meditation <= cfg.data;
                REG_CODE_RAW_WAVE:   codes_reg.code_raw_wave   <= cfg.data;
                REG_CODE_BAND_POWER: codes_reg.code_band_power <= cfg.data;
                REG_FEATURE_ENABLES: codes_reg.feature_enables <= cfg.data[3:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC1;
            len_reg        <= '0;
            byte_count_reg <= '0;
            sum_reg        <= '0;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (rx.rx_byte == sync_first_reg)
                    begin
                        phase_reg <= PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    phase_reg <= (rx.rx_byte == sync_second_reg) ? PH_LEN : PH_SYNC1;
                end
                PH_LEN:
                begin
                    if (rx.rx_byte > MAX_LEN)
                    begin
                        phase_reg <= PH_SYNC1;
                    end
                    else
                    begin
                        len_reg        <= rx.rx_byte;
                        byte_count_reg <= '0;
                        sum_reg        <= '0;
                        phase_reg      <= (rx.rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    sum_reg        <= sum_reg + rx.rx_byte;
                    byte_count_reg <= count_next;
                    if (count_next >= len_reg)
                    begin
                        phase_reg <= PH_CSUM;
                    end
                end
                PH_CSUM:
                begin
                    phase_reg <= PH_SYNC1;
                end
                default:
                begin
                    phase_reg <= PH_SYNC1;
                end
            endcase
        end
    end

    ehpp_walker #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .codes (codes_reg),
        .wr    (wr),
        .cmd   (cmd),
        .stat  (stat),
        .res   (res)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == PH_CSUM)) |=> (stat.busy && !rx.ready))
    else $error("walk did not start after checksum transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (phase_reg == PH_SYNC1))
    else $error("result pending while framer is inside a packet");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && res.last) |=> !res.valid)
    else $error("result after final transfer of a packet");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status) |-> (res.last && (res.band_value == 24'd0)))
    else $error("checksum status result malformed");

endmodule
